// ===== design/rt_pkg.sv =====
`default_nettype none

package rt_pkg;

    // Field widths fixed by the interface
    localparam int VALUE_W = 32;
    localparam int RANK_W  = 6;

    // Default list capacity
    localparam int MAX_ITEMS_DEF = 64;

    // Value travelling down the chain with its running count of smaller values
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic [RANK_W-1:0]         below;
    } token_t;

    // What a cell hands its left neighbor during readout
    typedef struct packed {
        logic              occ;
        logic [RANK_W-1:0] rank;
    } cell_state_t;

endpackage

`default_nettype wire

// ===== design/rt_cell.sv =====
`default_nettype none

module rt_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rt_pkg::token_t      tok_in,
    input  wire logic                shift,
    input  wire rt_pkg::cell_state_t nbr_state,
    output rt_pkg::token_t           tok_out,
    output rt_pkg::cell_state_t      state
);

    logic                              occ_reg;
    logic                              occ_next;
    logic signed [rt_pkg::VALUE_W-1:0] val_reg;
    logic signed [rt_pkg::VALUE_W-1:0] val_next;
    logic [rt_pkg::RANK_W-1:0]         rank_reg;
    logic [rt_pkg::RANK_W-1:0]         rank_next;
    logic                              tok_valid_reg;
    logic signed [rt_pkg::VALUE_W-1:0] tok_value_reg;
    logic [rt_pkg::RANK_W-1:0]         tok_below_reg;
    rt_pkg::token_t                    tok_next;

    logic stored_less;
    logic stored_greater;

    // Compare stored value against the passing one
    assign stored_less    = val_reg < tok_in.value;
    assign stored_greater = tok_in.value < val_reg;

    // Shift in the neighbor's state during readout; otherwise store into an empty cell, or count and forward
    always_comb
    begin
        occ_next  = occ_reg;
        val_next  = val_reg;
        rank_next = rank_reg;
        tok_next  = tok_in;
        tok_next.valid = 1'b0;
        if (shift)
        begin
            occ_next  = nbr_state.occ;
            rank_next = nbr_state.rank;
        end
        else if (tok_in.valid)
        begin
            if (!occ_reg)
            begin
                occ_next  = 1'b1;
                val_next  = tok_in.value;
                rank_next = tok_in.below;
            end
            else
            begin
                tok_next.valid = 1'b1;
                tok_next.below = tok_in.below + rt_pkg::RANK_W'(stored_less);
                if (stored_greater)
                begin
                    rank_next = rank_reg + rt_pkg::RANK_W'(1);
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            tok_valid_reg <= tok_next.valid;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        val_reg       <= val_next;
        rank_reg      <= rank_next;
        tok_value_reg <= tok_next.value;
        tok_below_reg <= tok_next.below;
    end

    assign tok_out.valid = tok_valid_reg;
    assign tok_out.value = tok_value_reg;
    assign tok_out.below = tok_below_reg;
    assign state.occ     = occ_reg;
    assign state.rank    = rank_reg;

endmodule

`default_nettype wire

// ===== design/rank_transform.sv =====
// Values enter the chain at one per cycle while the input is not stalled; a value moves one
// cell per cycle. Readout streams one rank per cycle from the head of the chain while the
// receiver does not stall. The input stalls after the last value of a list until readout ends.
// Reset: asynchronous, active low; clears chain occupancy, count, overflow and output valid.
`default_nettype none

module rank_transform #(
    parameter int MAX_ITEMS = rt_pkg::MAX_ITEMS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       value_valid,
    output logic                            value_stall,
    input  wire logic signed [rt_pkg::VALUE_W-1:0] value,
    input  wire logic                       last_item,
    output logic                            rank_valid,
    input  wire logic                       rank_stall,
    output logic [rt_pkg::RANK_W-1:0]       rank,
    output logic                            last_rank,
    output logic                            overflow
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    typedef enum logic [1:0] {
        FILL,
        SETTLE,
        DRAIN
    } state_t;

    state_t                    state_reg;
    logic [CNT_W-1:0]          count_reg;
    logic                      ovf_reg;
    logic                      rank_valid_reg;
    logic [rt_pkg::RANK_W-1:0] rank_reg;
    logic                      last_rank_reg;
    logic                      overflow_reg;

    rt_pkg::token_t      tok      [MAX_ITEMS+1];
    rt_pkg::cell_state_t cst      [MAX_ITEMS+1];
    logic [MAX_ITEMS-1:0] tok_busy;

    logic accept;
    logic inject;
    logic load;
    logic shift;
    logic busy;

    // Input handshake
    assign value_stall = (state_reg != FILL);
    assign accept      = value_valid && !value_stall;
    assign inject      = accept && (count_reg < CNT_W'(MAX_ITEMS));

    // Chain head token
    assign tok[0].valid = inject;
    assign tok[0].value = value;
    assign tok[0].below = '0;

    // Empty neighbor beyond the tail
    assign cst[MAX_ITEMS].occ  = 1'b0;
    assign cst[MAX_ITEMS].rank = '0;

    // Readout control
    assign load  = !rank_valid_reg || !rank_stall;
    assign shift = (state_reg == DRAIN) && load && cst[0].occ;
    assign busy  = |tok_busy;

    // Row of compare-and-count cells
    for (genvar j = 0; j < MAX_ITEMS; j++)
    begin : g_cell
        rt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .tok_in    (tok[j]),
            .shift     (shift),
            .nbr_state (cst[j+1]),
            .tok_out   (tok[j+1]),
            .state     (cst[j])
        );
        assign tok_busy[j] = tok[j+1].valid;
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FILL;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            rank_valid_reg <= 1'b0;
            rank_reg       <= '0;
            last_rank_reg  <= 1'b0;
            overflow_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                FILL:
                begin
                    if (accept)
                    begin
                        if (inject)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (last_item)
                        begin
                            state_reg <= SETTLE;
                        end
                    end
                end
                SETTLE:
                begin
                    if (!busy)
                    begin
                        state_reg <= DRAIN;
                    end
                end
                DRAIN:
                begin
                    if (load)
                    begin
                        rank_valid_reg <= cst[0].occ;
                        if (cst[0].occ)
                        begin
                            rank_reg       <= cst[0].rank;
                            last_rank_reg  <= !cst[1].occ;
                            overflow_reg   <= ovf_reg;
                        end
                        else
                        begin
                            state_reg <= FILL;
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= FILL;
                end
            endcase
        end
    end

    assign rank_valid = rank_valid_reg;
    assign rank       = rank_reg;
    assign last_rank  = last_rank_reg;
    assign overflow   = overflow_reg;

    // Last value of a list closes the input until readout ends
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_item) |=> value_stall)
        else $error("input still open after last value");

    // Readout never overlaps values still moving down the chain
    a_shift_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        shift |-> !busy)
        else $error("chain shifted with a value in flight");

    // Nothing follows the final rank of a list
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (rank_valid && !rank_stall && last_rank) |=> !rank_valid)
        else $error("rank emitted after final rank");

    // Count never exceeds capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("item count beyond capacity");

endmodule

`default_nettype wire

// ===== verif/rank_checker.sv =====
module rank_checker #(
    parameter int MAX_ITEMS = rt_pkg::MAX_ITEMS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              value_valid,
    input  wire logic                              value_stall,
    input  wire logic signed [rt_pkg::VALUE_W-1:0] value,
    input  wire logic                              last_item,
    input  wire logic                              rank_valid,
    input  wire logic                              rank_stall,
    input  wire logic [rt_pkg::RANK_W-1:0]         rank,
    input  wire logic                              last_rank,
    input  wire logic                              overflow,
    output int                                     errors,
    output int                                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam int CAP   = (MAX_ITEMS > DEPTH) ? DEPTH : MAX_ITEMS;

    typedef struct packed {
        logic [rt_pkg::RANK_W-1:0] rank;
        logic                      last_rank;
        logic                      overflow;
    } rank_txn_t;

    // Mirror of the list held by the block
    logic signed [rt_pkg::VALUE_W-1:0] list_vals  [DEPTH];
    logic [rt_pkg::RANK_W-1:0]         list_ranks [DEPTH];
    int                                list_len;
    bit                                list_dropped;

    // Ranks owed by the block, oldest first
    rank_txn_t                         owed_ranks [$];

    always @(posedge clk or negedge rst_n)
    begin : rank_predict_check
        int        below;
        rank_txn_t got;
        rank_txn_t want;
        if (!rst_n)
        begin
            list_len     = 0;
            list_dropped = 0;
            owed_ranks.delete();
            errors       = 0;
            outstanding <= 0;
        end
        else
        begin
            // Value transaction: insert into the running rank table
            if (value_valid && !value_stall)
            begin
                if (list_len < CAP)
                begin
                    below = 0;
                    for (int j = 0; j < list_len; j++)
                    begin
                        if (list_vals[j] < value)
                            below++;
                        else if (value < list_vals[j])
                            list_ranks[j] = list_ranks[j] + 1'b1;
                    end
                    list_vals[list_len]  = value;
                    list_ranks[list_len] = below[rt_pkg::RANK_W-1:0];
                    list_len++;
                end
                else
                    list_dropped = 1;

                // End of list: the whole table is owed in arrival order
                if (last_item)
                begin
                    for (int j = 0; j < list_len; j++)
                    begin
                        want.rank      = list_ranks[j];
                        want.last_rank = (j == list_len - 1);
                        want.overflow  = list_dropped;
                        owed_ranks.push_back(want);
                    end
                    list_len     = 0;
                    list_dropped = 0;
                end
            end

            // Rank transaction: compare against the oldest owed rank
            if (rank_valid && !rank_stall)
            begin
                got.rank      = rank;
                got.last_rank = last_rank;
                got.overflow  = overflow;
                if (owed_ranks.size() == 0)
                begin
                    $error("unexpected rank transaction: rank=%0d last_rank=%0b overflow=%0b",
                           got.rank, got.last_rank, got.overflow);
                    errors++;
                end
                else
                begin
                    want = owed_ranks.pop_front();
                    if (got.rank !== want.rank)
                    begin
                        $error("rank: expected %0d, got %0d", want.rank, got.rank);
                        errors++;
                    end
                    if (got.last_rank !== want.last_rank)
                    begin
                        $error("last_rank: expected %0b, got %0b", want.last_rank, got.last_rank);
                        errors++;
                    end
                    if (got.overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
                        errors++;
                    end
                end
            end

            outstanding <= owed_ranks.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ITEMS   = 460;
    localparam int IDLE_PCT    = 26;
    localparam int STALL_LIMIT = 3000;
    localparam int TAIL_CYCLES = 200;

    logic                              clk         = 1'b0;
    logic                              rst_n       = 1'b0;
    logic                              value_valid = 1'b0;
    logic signed [rt_pkg::VALUE_W-1:0] value       = '0;
    logic                              last_item   = 1'b0;
    logic                              rank_stall  = 1'b0;
    logic                              value_stall;
    logic                              rank_valid;
    logic [rt_pkg::RANK_W-1:0]         rank;
    logic                              last_rank;
    logic                              overflow;

    int errors;
    int outstanding;
    int items_sent;
    int lists_sent;
    int idle_cycles = 0;
    bit calm = 1'b0;

    rank_transform u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .value       (value),
        .last_item   (last_item),
        .rank_valid  (rank_valid),
        .rank_stall  (rank_stall),
        .rank        (rank),
        .last_rank   (last_rank),
        .overflow    (overflow)
    );

    rank_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .value       (value),
        .last_item   (last_item),
        .rank_valid  (rank_valid),
        .rank_stall  (rank_stall),
        .rank        (rank),
        .last_rank   (last_rank),
        .overflow    (overflow),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver backpressure, off during the calm stretch
    always @(posedge clk)
        rank_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

    // Watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((value_valid && !value_stall) || (rank_valid && !rank_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // One value transaction, with optional idle cycles ahead of it
    task automatic send_value(input logic signed [rt_pkg::VALUE_W-1:0] v, input logic lst);
        while (!calm && ($urandom_range(99) < IDLE_PCT))
        begin
            value_valid <= 1'b0;
            @(posedge clk);
        end
        value_valid <= 1'b1;
        value       <= v;
        last_item   <= lst;
        do
            @(posedge clk);
        while (value_stall);
        items_sent++;
    endtask

    // Hold off the sender until every owed rank has come out
    task automatic drain_ranks();
        value_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Mix of extremes, clustered values (duplicates) and full-range values
    function automatic logic signed [rt_pkg::VALUE_W-1:0] pick_value();
        int mode;
        mode = $urandom_range(9);
        if (mode == 0)
        begin
            case ($urandom_range(4))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return 32'sh0000_0000;
                3: return -32'sd1;
                default: return 32'sd1;
            endcase
        end
        else if (mode <= 3)
            return $signed($urandom_range(15)) - 32'sd8;
        else
            return $urandom;
    endfunction

    task automatic send_list(input int len);
        for (int k = 0; k < len; k++)
            send_value(pick_value(), k == len - 1);
        lists_sent++;
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return $urandom_range(12, 1);
        else if (r < 90)
            return $urandom_range(40, 13);
        else if (r < 95)
            return $urandom_range(64, 60);
        else
            return $urandom_range(70, 65);
    endfunction

    initial
    begin
        bit paused;
        int len;
        items_sent  = 0;
        lists_sent  = 0;
        paused      = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single-element list at the top of the range
        send_value(32'sh7FFF_FFFF, 1'b1);
        // Extremes of the signed range
        send_value(32'sh8000_0000, 1'b0);
        send_value(32'sh7FFF_FFFF, 1'b0);
        send_value(32'sh0000_0000, 1'b0);
        send_value(-32'sd1, 1'b0);
        send_value(32'sd1, 1'b1);
        // Duplicates share the strict-less rank
        send_value(32'sd5, 1'b0);
        send_value(32'sd5, 1'b0);
        send_value(-32'sd3, 1'b0);
        send_value(32'sd5, 1'b0);
        send_value(-32'sd3, 1'b0);
        send_value(32'sd7, 1'b1);
        send_value(32'sh7FFF_FFFF, 1'b0);
        send_value(32'sh7FFF_FFFF, 1'b1);
        // Descending order pushes every earlier rank up
        send_value(32'sd3, 1'b0);
        send_value(32'sd2, 1'b0);
        send_value(32'sd1, 1'b0);
        send_value(32'sd0, 1'b1);

        drain_ranks();
        lists_sent = 0;

        // Random lists; one exactly full, one past capacity (marked value dropped)
        while (items_sent < NUM_ITEMS)
        begin
            if (lists_sent == 3)
                len = 64;
            else if (lists_sent == 6)
                len = 68;
            else
                len = pick_length();
            calm = (items_sent >= 200) && (items_sent < 300);
            send_list(len);
            if (!paused && items_sent >= 350)
            begin
                drain_ranks();
                paused = 1;
            end
        end
        calm = 1'b0;

        // Let every owed rank come out, then a latency tail
        drain_ranks();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
